### rtl/elpc_pkg.sv
// Package: shared types, constants and status codes for the expiring probe cache.
package elpc_pkg;

  localparam int unsigned IndexBitsDefault = 8;
  localparam logic [31:0] LifetimeReset = 32'd3600;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_EXPIRED  = 3'd2,
    ST_SAVED    = 3'd3,
    ST_FULL     = 3'd4,
    ST_DISABLED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LREAD,
    S_LCHK,
    S_DEL_RD,
    S_DEL_CHK,
    S_SREAD,
    S_SCHK,
    S_DONE
  } state_t;

  localparam logic [0:0] CMD_LOOKUP = 1'b0;
  localparam logic [0:0] CMD_SAVE   = 1'b1;

  localparam logic REG_ENABLE   = 1'b0;
  localparam logic REG_LIFETIME = 1'b1;

  // Table entry as stored in the slot memory.
  typedef struct packed {
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [31:0] value;
    logic [31:0] stamp;
  } entry_t;

endpackage

### rtl/elpc_regs.sv
// Configuration registers on an APB-style port.
module elpc_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic        enable_o,
  output logic [31:0] lifetime_o
);
  import elpc_pkg::*;

  logic        enable_r, enable_nxt;
  logic [31:0] lifetime_r, lifetime_nxt;
  logic        wr;
  logic        sel;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel & cfg_penable & cfg_pwrite;
  assign sel = cfg_paddr[2];

  // Register write decode.
  always_comb begin
    enable_nxt   = enable_r;
    lifetime_nxt = lifetime_r;
    if (wr && cfg_paddr[1:0] == 2'b00) begin
      unique case (sel)
        REG_ENABLE:   enable_nxt   = cfg_pwdata[0];
        REG_LIFETIME: lifetime_nxt = cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      lifetime_r <= LifetimeReset;
    end else begin
      enable_r   <= enable_nxt;
      lifetime_r <= lifetime_nxt;
    end
  end

  // Read back.
  always_comb begin
    unique case (sel)
      REG_ENABLE:   cfg_prdata = {31'd0, enable_r};
      REG_LIFETIME: cfg_prdata = lifetime_r;
      default:      cfg_prdata = 32'd0;
    endcase
  end

  assign enable_o   = enable_r;
  assign lifetime_o = lifetime_r;
endmodule

### rtl/expiring_linear_probe_cache.sv
// Top level: probe sequencer, slot memory and configuration registers.
//
//  channel  | dir | handshake          | payload
//  in_      | in  | tvalid/tready      | tdata: command, key_low, key_high, entry_value, now
//  out_     | out | tvalid/tready      | tdata: status, found_value, slot_index
//  cfg_     | in  | psel/penable/pwrite| two registers at byte 0 and 4
//
// Each probed slot is read and then checked; a lookup that drops an expired entry
// then reads and checks each occupied slot in the backward-shift repair.
// All probes share one memory read port and one key comparator. in_tready is low
// while an item is at work and while its result waits. Reset clears valid bits and
// fill count at once. A stalled result holds until taken.
module expiring_linear_probe_cache #(
  parameter int unsigned INDEX_BITS = elpc_pkg::IndexBitsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [0] command, [64:1] key_low, [128:65] key_high, [160:129] entry_value,
  // [192:161] now_seconds, zero fill
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status, [34:3] found_value, [42:35] slot_index, zero fill
  output logic [47:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import elpc_pkg::*;

  localparam int unsigned Slots = 1 << INDEX_BITS;
  localparam logic [INDEX_BITS:0] FullMark = (INDEX_BITS+1)'(Slots - 1);
  typedef logic [INDEX_BITS-1:0] idx_t;

  logic        enable;
  logic [31:0] lifetime;

  elpc_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .enable_o(enable), .lifetime_o(lifetime)
  );

  // Slot memory with registered read, and valid bits in flip-flops.
  entry_t mem [Slots];
  entry_t rd_q;
  logic   [Slots-1:0] valid_r, valid_nxt;
  idx_t   rd_addr;
  logic   we;
  idx_t   wa;
  entry_t wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_addr];
  end

  state_t state_r, state_nxt;
  logic [63:0] klo_r, khi_r;
  logic [31:0] val_r, now_r;
  idx_t        u_r, u_nxt, hole_r, hole_nxt;
  logic [INDEX_BITS:0] n_r, n_nxt;
  logic [INDEX_BITS:0] fill_r, fill_nxt;
  status_t     st_r, st_nxt;
  logic [31:0] fv_r, fv_nxt;
  idx_t        slot_r, slot_nxt;
  logic        take;
  logic        match;
  logic [31:0] age;
  idx_t        kh;
  logic        stays;

  assign take  = in_tvalid & in_tready;
  assign match = (rd_q.key_lo == klo_r) && (rd_q.key_hi == khi_r);
  assign age   = now_r - rd_q.stamp;
  assign kh    = rd_q.key_lo[INDEX_BITS-1:0];
  always_comb begin
    if (hole_r < u_r) stays = (hole_r < kh) && (kh <= u_r);
    else              stays = (hole_r < kh) || (kh <= u_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (take) begin
        if (!enable) state_nxt = S_DONE;
        else if (in_tdata[0] == CMD_SAVE)
          state_nxt = (fill_r >= FullMark) ? S_DONE : S_SREAD;
        else state_nxt = S_LREAD;
      end
      S_LREAD: state_nxt = S_LCHK;
      S_LCHK: begin
        if (!valid_r[u_r]) state_nxt = S_DONE;
        else if (match) state_nxt = (age > lifetime) ? S_DEL_RD : S_DONE;
        else if (n_r == (INDEX_BITS+1)'(Slots - 1)) state_nxt = S_DONE;
        else state_nxt = S_LREAD;
      end
      S_DEL_RD: state_nxt = (u_r == hole_r || !valid_r[u_r]) ? S_DONE : S_DEL_CHK;
      S_DEL_CHK: state_nxt = S_DEL_RD;
      S_SREAD: state_nxt = S_SCHK;
      S_SCHK: state_nxt = valid_r[u_r] ? S_SREAD : S_DONE;
      S_DONE: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    u_nxt = u_r; hole_nxt = hole_r; n_nxt = n_r; fill_nxt = fill_r;
    st_nxt = st_r; fv_nxt = fv_r; slot_nxt = slot_r; valid_nxt = valid_r;
    we = 1'b0; wa = u_r; wd = rd_q; rd_addr = u_r;
    unique case (state_r)
      S_IDLE: if (take) begin
        u_nxt = in_tdata[INDEX_BITS:1];
        n_nxt = '0;
        fv_nxt = '0; slot_nxt = '0;
        if (!enable) st_nxt = ST_DISABLED;
        else if (in_tdata[0] == CMD_SAVE && fill_r >= FullMark) st_nxt = ST_FULL;
        else st_nxt = ST_MISS;
      end
      S_LCHK: begin
        if (valid_r[u_r] && match) begin
          slot_nxt = u_r;
          if (age > lifetime) begin
            st_nxt = ST_EXPIRED;
            valid_nxt[u_r] = 1'b0;
            hole_nxt = u_r;
            u_nxt = u_r + idx_t'(1);
            if (fill_r != '0) fill_nxt = fill_r - 1'b1;
          end else begin
            st_nxt = ST_HIT;
            fv_nxt = rd_q.value;
          end
        end else begin
          u_nxt = u_r + idx_t'(1);
          n_nxt = n_r + 1'b1;
        end
      end
      S_DEL_CHK: begin
        if (!stays) begin
          we = 1'b1; wa = hole_r; wd = rd_q;
          valid_nxt[hole_r] = 1'b1;
          valid_nxt[u_r] = 1'b0;
          hole_nxt = u_r;
        end
        u_nxt = u_r + idx_t'(1);
      end
      S_SCHK: begin
        if (valid_r[u_r]) u_nxt = u_r + idx_t'(1);
        else begin
          we = 1'b1; wa = u_r;
          wd = '{key_lo: klo_r, key_hi: khi_r, value: val_r, stamp: now_r};
          valid_nxt[u_r] = 1'b1;
          fill_nxt = fill_r + 1'b1;
          st_nxt = ST_SAVED;
          slot_nxt = u_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      klo_r <= in_tdata[64:1];
      khi_r <= in_tdata[128:65];
      val_r <= in_tdata[160:129];
      now_r <= in_tdata[192:161];
    end
    u_r <= u_nxt; hole_r <= hole_nxt; n_r <= n_nxt;
    st_r <= st_nxt; fv_r <= fv_nxt; slot_r <= slot_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DONE);
  assign out_tdata  = {5'd0, 8'(slot_r), fv_r, st_r};
endmodule

### tb/expiring_linear_probe_cache_test.sv
// Testbench for the expiring linear-probe cache: random stream stimulus checked against a predictor.
module expiring_linear_probe_cache_test;
  import elpc_pkg::*;

  localparam int SLOTS = 256;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [2:0] ADDR_ENABLE = {1'b0, REG_ENABLE, 1'b0} << 1;
  localparam logic [2:0] ADDR_LIFETIME = {1'b0, REG_LIFETIME, 1'b0} << 1;

  typedef struct {
    logic        cmd;
    logic [63:0] klo;
    logic [63:0] khi;
    logic [31:0] val;
    logic [31:0] now;
  } cmd_item_t;

  typedef struct {
    status_t     status;
    logic [31:0] found;
    logic [7:0]  slot;
  } answer_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [199:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  expiring_linear_probe_cache #(.INDEX_BITS(8)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow copy of the table and registers.
  logic        tbl_valid [SLOTS];
  logic [63:0] tbl_klo [SLOTS];
  logic [63:0] tbl_khi [SLOTS];
  logic [31:0] tbl_val [SLOTS];
  logic [31:0] tbl_time [SLOTS];
  int unsigned tbl_fill;
  logic        cur_enable;
  logic [31:0] cur_lifetime;

  cmd_item_t   pending_items[$];
  answer_t     awaited_answers[$];
  int          error_count;
  int unsigned cycle_count;
  logic        in_took;
  int          send_gap;
  int          hold_left;
  int          long_hold_req;
  int          long_hold_done;
  bit          quiet;
  logic [31:0] clock_now;
  logic [63:0] pool_lo [20];
  logic [63:0] pool_hi [20];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Work out the answer to one command and update the shadow table.
  function automatic answer_t cache_answer(cmd_item_t it);
    answer_t    a;
    logic [7:0] u;
    logic [7:0] hole;
    logic [7:0] j;
    logic [7:0] k;
    logic       stays;
    int         n;
    a.status = ST_MISS;
    a.found = '0;
    a.slot = '0;
    u = it.klo[7:0];
    if (!cur_enable) begin
      a.status = ST_DISABLED;
    end else if (it.cmd == CMD_LOOKUP) begin
      for (n = 0; n < SLOTS; n++) begin
        if (!tbl_valid[u]) break;
        if (tbl_klo[u] == it.klo && tbl_khi[u] == it.khi) begin
          a.slot = u;
          if (32'(it.now - tbl_time[u]) > cur_lifetime) begin
            a.status = ST_EXPIRED;
            // Backward-shift repair of the cluster behind the dropped entry.
            hole = u;
            j = u;
            tbl_valid[hole] = 1'b0;
            while (1'b1) begin
              j = j + 8'd1;
              if (j == hole || !tbl_valid[j]) break;
              k = tbl_klo[j][7:0];
              stays = (hole < j) ? (hole < k && k <= j) : (hole < k || k <= j);
              if (!stays) begin
                tbl_valid[hole] = 1'b1;
                tbl_klo[hole] = tbl_klo[j];
                tbl_khi[hole] = tbl_khi[j];
                tbl_val[hole] = tbl_val[j];
                tbl_time[hole] = tbl_time[j];
                tbl_valid[j] = 1'b0;
                hole = j;
              end
            end
            if (tbl_fill > 0) tbl_fill--;
          end else begin
            a.status = ST_HIT;
            a.found = tbl_val[u];
          end
          break;
        end
        u = u + 8'd1;
      end
    end else if (tbl_fill + 1 >= SLOTS) begin
      a.status = ST_FULL;
    end else begin
      for (n = 0; n < SLOTS && tbl_valid[u]; n++) u = u + 8'd1;
      tbl_valid[u] = 1'b1;
      tbl_klo[u] = it.klo;
      tbl_khi[u] = it.khi;
      tbl_val[u] = it.val;
      tbl_time[u] = it.now;
      tbl_fill++;
      a.status = ST_SAVED;
      a.slot = u;
    end
    return a;
  endfunction

  task automatic queue_cmd(logic cmd, logic [63:0] klo, logic [63:0] khi,
                           logic [31:0] val, logic [31:0] now);
    cmd_item_t it;
    it.cmd = cmd;
    it.klo = klo;
    it.khi = khi;
    it.val = val;
    it.now = now;
    pending_items.push_back(it);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_ENABLE) cur_enable = data[0];
    else cur_lifetime = data;
  endtask

  // Wait until every queued item has gone in and every answer has come back.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() > 0 || in_tvalid || awaited_answers.size() > 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // One random command, biased towards a small pool of colliding keys.
  task automatic queue_random();
    int          p;
    logic [63:0] klo;
    logic [63:0] khi;
    int          r;
    p = $urandom_range(0, 19);
    klo = {$urandom, $urandom};
    khi = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 60) begin
      klo = pool_lo[p];
      khi = pool_hi[p];
    end
    r = $urandom_range(0, 99);
    if (r < 70) clock_now = clock_now + $urandom_range(0, 20);
    else if (r < 97) clock_now = clock_now + $urandom_range(1000, 5000);
    else clock_now = clock_now + $urandom;
    queue_cmd($urandom_range(0, 99) < 45 ? CMD_SAVE : CMD_LOOKUP, klo, khi, $urandom,
              clock_now);
  endtask

  // Sender: offers the next pending item after a random gap.
  always @(negedge clk) begin : send_proc
    cmd_item_t nxt;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        in_tdata <= {7'd0, nxt.now, nxt.val, nxt.khi, nxt.klo, nxt.cmd};
        in_tvalid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and a long hold-off whenever one is requested.
  always @(negedge clk) begin : take_proc
    int g;
    if (long_hold_req != long_hold_done) begin
      long_hold_done <= long_hold_done + 1;
      hold_left <= $urandom_range(300, 500);
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        hold_left <= g - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each accepted item and checks each accepted result.
  always @(posedge clk) begin : watch_proc
    cmd_item_t acc;
    answer_t   want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n) begin
      in_took <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        acc.cmd = in_tdata[0];
        acc.klo = in_tdata[64:1];
        acc.khi = in_tdata[128:65];
        acc.val = in_tdata[160:129];
        acc.now = in_tdata[192:161];
        awaited_answers.push_back(cache_answer(acc));
      end
      if (out_tvalid && out_tready) begin
        if (awaited_answers.size() == 0) begin
          $error("result with none expected: %h", out_tdata);
          error_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (out_tdata[2:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[2:0]);
            error_count++;
          end
          if (out_tdata[34:3] !== want.found) begin
            $error("found_value: expected %h, got %h", want.found, out_tdata[34:3]);
            error_count++;
          end
          if (out_tdata[42:35] !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, out_tdata[42:35]);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    int          ph;
    int          i;
    logic [31:0] lifetimes [4];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_took = 1'b0;
    send_gap = 0;
    hold_left = 0;
    long_hold_req = 0;
    long_hold_done = 0;
    quiet = 1'b0;
    error_count = 0;
    cycle_count = 0;
    clock_now = 32'd100;
    cur_enable = 1'b0;
    cur_lifetime = LifetimeReset;
    tbl_fill = 0;
    for (i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    // Pool keys share a few home slots, some near the top so probes wrap.
    for (i = 0; i < 20; i++) begin
      pool_lo[i] = {$urandom, 24'($urandom), 8'($urandom_range(250, 261))};
      pool_hi[i] = {$urandom, $urandom};
    end
    lifetimes[0] = 32'd1;
    lifetimes[1] = 32'd10;
    lifetimes[2] = LifetimeReset;
    lifetimes[3] = 32'hFFFF_FFFF;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: both commands answer disabled.
    queue_cmd(CMD_SAVE, 64'h5, 64'h5, 32'h1, 32'd0);
    queue_cmd(CMD_LOOKUP, 64'h5, 64'h5, 32'h0, 32'd0);
    wait_idle();

    // Extremes, wrap-around at the top slot, age at the limit, expiry with repair.
    cfg_write(ADDR_ENABLE, 32'd1);
    queue_cmd(CMD_SAVE, '1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_SAVE, '0, '0, 32'h0, 32'h0);
    queue_cmd(CMD_SAVE, 64'hFF, 64'h1234, 32'hA5A5_5A5A, 32'h0);
    queue_cmd(CMD_LOOKUP, '1, '1, 32'h0, 32'h0000_0E0F);
    queue_cmd(CMD_LOOKUP, 64'hFF, 64'h1234, 32'h0, 32'h0);
    queue_cmd(CMD_LOOKUP, '1, '1, 32'h0, 32'h0000_0E10);
    queue_cmd(CMD_LOOKUP, 64'hFF, 64'h1234, 32'h0, 32'h10);
    queue_cmd(CMD_LOOKUP, 64'h0000_0000_0000_0105, 64'h9, 32'h0, 32'h10);
    queue_cmd(CMD_SAVE, '0, '0, 32'h1111_1111, 32'h20);
    queue_cmd(CMD_LOOKUP, '0, '0, 32'h0, 32'h20);
    queue_cmd(CMD_LOOKUP, '0, 64'h1, 32'h0, 32'h20);
    wait_idle();

    // Lifetime of one second: one second old is kept, two is dropped.
    cfg_write(ADDR_LIFETIME, 32'd1);
    queue_cmd(CMD_SAVE, 64'h42, 64'h42, 32'h77, 32'd500);
    queue_cmd(CMD_LOOKUP, 64'h42, 64'h42, 32'h0, 32'd501);
    queue_cmd(CMD_LOOKUP, 64'h42, 64'h42, 32'h0, 32'd502);
    wait_idle();

    // Longest lifetime: even the greatest age is kept.
    cfg_write(ADDR_LIFETIME, 32'hFFFF_FFFF);
    queue_cmd(CMD_SAVE, 64'h43, 64'h43, 32'h88, 32'd1);
    queue_cmd(CMD_LOOKUP, 64'h43, 64'h43, 32'h0, 32'd0);
    wait_idle();

    // Random phases at several lifetimes; the first one holds the receiver off, the third runs without gaps.
    for (ph = 0; ph < 4; ph++) begin
      cfg_write(ADDR_LIFETIME, lifetimes[ph]);
      quiet = (ph == 2);
      for (i = 0; i < 40; i++) queue_random();
      if (ph == 0) long_hold_req = long_hold_req + 1;
      wait_idle();
    end
    quiet = 1'b0;

    // Fill the table until saves are rejected as full.
    cfg_write(ADDR_LIFETIME, LifetimeReset);
    for (i = 0; i < 265; i++)
      queue_cmd(CMD_SAVE, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, clock_now);
    wait_idle();

    // Drain it again: every stored key is looked up once it has aged out.
    cfg_write(ADDR_LIFETIME, 32'd100);
    clock_now = clock_now + 32'd5000;
    for (i = 0; i < SLOTS; i++)
      if (tbl_valid[i]) queue_cmd(CMD_LOOKUP, tbl_klo[i], tbl_khi[i], 32'h0, clock_now);
    for (i = 0; i < 30; i++) queue_random();
    wait_idle();

    // Disabled again with entries present.
    cfg_write(ADDR_ENABLE, 32'd0);
    for (i = 0; i < 4; i++) queue_random();
    wait_idle();

    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/elpc_pkg.sv
rtl/elpc_regs.sv
rtl/expiring_linear_probe_cache.sv
tb/expiring_linear_probe_cache_test.sv
